### rtl/efws_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efws_pkg: shared types and constants for the earliest-free worker scheduler
// Field widths, function codes, controller state codes and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package efws_pkg;

    localparam int unsigned DEF_MAX_WORKERS = 16;

    // item fields
    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned WIDX_W   = 4;
    localparam int unsigned CAP_W    = 10;
    localparam int unsigned AMOUNT_W = 20;
    localparam int unsigned TIME_W   = 32;

    // stream payloads, padded to whole bytes
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 80;

    // configuration port
    localparam int unsigned CFG_W     = 5;
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;
    localparam logic        REG_ACTIVE_WORKERS = 1'b0;  // word index in paddr[2]

    // function codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TASK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // restoring divider: one quotient bit per step
    localparam int unsigned DIV_CNT_W = 5;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOAD = 6'b000010,
        ST_SCAN = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_WB   = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    typedef struct packed {
        logic accept;    // take the input transfer, reset scan and divider
        logic load_wr;   // write a loaded capacity into the table
        logic scan_run;  // step the table scan
        logic div_step;  // one divider step
        logic wb;        // finish time update and write back
        logic out_load;  // load the output register
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] in_func;  // function of the item on the input
        logic [FUNC_W-1:0] func;     // function of the item in work
        logic              scan_done;
        logic              div_done;
        logic              out_free;
    } sts_t;

endpackage
`default_nettype wire

### rtl/efws_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efws_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module efws_ram #(
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output      logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/efws_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efws_datapath: worker table, scan, divider and output register
// Table entries hold {capacity, finish}; an entry never written reads as
// capacity one, finish zero through its valid bit.
// ----------------------------------------------------------------------------
module efws_datapath
    import efws_pkg::*;
#(
    parameter int unsigned MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output      sts_t                 sts,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic [CFG_W-1:0]     active_workers,
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    output      logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned AW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int unsigned CW    = $clog2(MAX_WORKERS + 1);
    localparam int unsigned ENT_W = CAP_W + TIME_W;

    // input item
    logic [FUNC_W-1:0]   func_reg;
    logic [WIDX_W-1:0]   widx_reg;
    logic [CAP_W-1:0]    cap_in_reg;

    // scan
    logic [CW-1:0]       n_eff;
    logic [CW-1:0]       cnt_reg;
    logic                pv_reg;
    logic [AW-1:0]       pidx_reg;
    logic                hit_reg;
    logic [AW-1:0]       best_idx_reg;
    logic [CAP_W-1:0]    best_cap_reg;
    logic [TIME_W-1:0]   best_fin_reg;
    logic [TIME_W-1:0]   span_reg;
    logic [CAP_W-1:0]    ent_cap;
    logic [TIME_W-1:0]   ent_fin;

    // divider
    logic [CAP_W-1:0]     rem_reg;
    logic [AMOUNT_W-1:0]  quo_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic [CAP_W-1:0]     divisor;
    logic [CAP_W:0]       rem_sh;
    logic                 rem_ge;
    logic [CAP_W:0]       rem_sub;

    // write back
    logic [AMOUNT_W:0]   dur;
    logic [TIME_W:0]     fin_sum;
    logic [TIME_W-1:0]   end_next;
    logic [TIME_W-1:0]   end_reg;

    // table
    logic [MAX_WORKERS-1:0] valid_reg;
    logic [8:0]          widx_ext;
    logic [AW-1:0]       widx_addr;
    logic                widx_ok;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENT_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [ENT_W-1:0]    ram_rdata;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] out_next;
    logic [8:0]           best_ext;

    // zero acts as one, above the table size acts as the table size
    always_comb begin
        if (active_workers == '0) begin
            n_eff = CW'(1);
        end else if (32'(active_workers) > MAX_WORKERS) begin
            n_eff = CW'(MAX_WORKERS);
        end else begin
            n_eff = CW'(active_workers);
        end
    end

    assign widx_ext  = 9'(widx_reg);
    assign widx_addr = widx_ext[AW-1:0];
    assign widx_ok   = 32'(widx_reg) < MAX_WORKERS;

    assign ram_re    = cmd.scan_run && (cnt_reg < n_eff);
    assign ram_we    = cmd.wb || (cmd.load_wr && widx_ok);
    assign ram_waddr = cmd.wb ? best_idx_reg : widx_addr;
    assign ram_wdata = cmd.wb ? {best_cap_reg, end_next} : {cap_in_reg, {TIME_W{1'b0}}};

    efws_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (MAX_WORKERS),
        .ADDR_W (AW)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign ent_cap = hit_reg ? ram_rdata[ENT_W-1:TIME_W] : CAP_W'(1);
    assign ent_fin = hit_reg ? ram_rdata[TIME_W-1:0] : '0;

    // restoring division step, zero capacity divides by one
    assign divisor = (best_cap_reg == '0) ? CAP_W'(1) : best_cap_reg;
    assign rem_sh  = {rem_reg, quo_reg[AMOUNT_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    // ceiling and saturating finish update
    assign dur      = {1'b0, quo_reg} + (AMOUNT_W+1)'(rem_reg != '0);
    assign fin_sum  = {1'b0, best_fin_reg} + (TIME_W+1)'(dur);
    assign end_next = fin_sum[TIME_W] ? {TIME_W{1'b1}} : fin_sum[TIME_W-1:0];

    assign best_ext = 9'(best_idx_reg);

    always_comb begin
        case (func_reg)
            FUNC_LOAD:  out_next = M_TDATA_W'({{(2*TIME_W){1'b0}}, cap_in_reg, widx_reg});
            FUNC_TASK:  out_next = M_TDATA_W'({end_reg, best_fin_reg, best_cap_reg,
                                               best_ext[WIDX_W-1:0]});
            FUNC_QUERY: out_next = M_TDATA_W'({span_reg, {(TIME_W+CAP_W+WIDX_W){1'b0}}});
            default:    out_next = '0;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            pv_reg       <= 1'b0;
            dcnt_reg     <= '0;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                cnt_reg  <= '0;
                pv_reg   <= 1'b0;
                dcnt_reg <= '0;
            end else if (cmd.scan_run) begin
                if (ram_re) begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
                pv_reg <= ram_re;
            end else if (cmd.div_step) begin
                dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
            end
            if (cmd.load_wr && widx_ok) begin
                valid_reg[widx_addr] <= 1'b1;
            end
            if (cmd.wb) begin
                valid_reg[best_idx_reg] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            func_reg   <= s_tdata[FUNC_W-1:0];
            widx_reg   <= s_tdata[FUNC_W +: WIDX_W];
            cap_in_reg <= s_tdata[FUNC_W+WIDX_W +: CAP_W];
            quo_reg    <= s_tdata[FUNC_W+WIDX_W+CAP_W +: AMOUNT_W];
            rem_reg    <= '0;
            span_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_sub[CAP_W-1:0] : rem_sh[CAP_W-1:0];
            quo_reg <= {quo_reg[AMOUNT_W-2:0], rem_ge};
        end
        if (cmd.scan_run) begin
            pidx_reg <= cnt_reg[AW-1:0];
            hit_reg  <= valid_reg[cnt_reg[AW-1:0]];
            if (pv_reg) begin
                // strict compare keeps the lowest index on ties
                if (pidx_reg == '0 || ent_fin < best_fin_reg) begin
                    best_idx_reg <= pidx_reg;
                    best_cap_reg <= ent_cap;
                    best_fin_reg <= ent_fin;
                end
                if (ent_fin > span_reg) begin
                    span_reg <= ent_fin;
                end
            end
        end
        if (cmd.wb) begin
            end_reg <= end_next;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= out_next;
        end
    end

    assign sts.in_func   = s_tdata[FUNC_W-1:0];
    assign sts.func      = func_reg;
    assign sts.scan_done = pv_reg && (CW'(pidx_reg) == (n_eff - CW'(1)));
    assign sts.div_done  = dcnt_reg == DIV_CNT_W'(AMOUNT_W - 1);
    assign sts.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

### rtl/efws_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// efws_ctrl: scheduler sequencer
// Walks one item through load, scan, divide, write back and output.
// ----------------------------------------------------------------------------
module efws_ctrl
    import efws_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output      logic s_tready,
    input  wire sts_t sts,
    output      cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (sts.in_func == FUNC_LOAD) begin
                        state_next = ST_LOAD;
                    end else if (sts.in_func == FUNC_TASK || sts.in_func == FUNC_QUERY) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load_wr = 1'b1;
                state_next  = ST_OUT;
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    state_next = (sts.func == FUNC_TASK) ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

### rtl/earliest_free_worker_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler: greedy list scheduler, earliest finish
// Keeps a capacity and a finish time per worker. Load sets a capacity and
// clears the finish, task goes to the earliest free active worker and adds
// ceil(task/capacity), query returns the largest active finish time.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: func, worker_index, capacity,
//          |     |                    |          task_amount
//  m_      | out | m_tvalid/m_tready  | m_tdata: chosen_worker, worker_capacity,
//          |     |                    |          start_time, end_time
//  apb     | in  | psel/penable/pready| active_workers at byte address 0
//
//  Per item, with m_tready high: an unused code goes straight to the output,
//    a load writes the table, a query scans, and a task scans, divides and
//    writes back; the scan reads one table entry per cycle
//    from the single RAM read port, and the divider retires one quotient bit
//    per cycle, then the write back step updates the finish time.
//  Reset (aresetn low, synchronous) clears the FSM, the entry valid bits and
//  the output valid; no clearing pass is needed, unwritten entries read as
//  capacity one, finish zero.
//  One item in flight; the next is taken once the result sits in the output
//  register, which holds it while m_tready is low.
// ----------------------------------------------------------------------------
module earliest_free_worker_scheduler
    import efws_pkg::*;
#(
    parameter int unsigned MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // input stream
    input  wire logic                 s_tvalid,
    output      logic                 s_tready,
    // [1:0] func, [5:2] worker_index, [15:6] capacity, [35:16] task_amount
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // result stream
    output      logic                 m_tvalid,
    input  wire logic                 m_tready,
    // [3:0] chosen_worker, [13:4] worker_capacity, [45:14] start_time,
    // [77:46] end_time
    output      logic [M_TDATA_W-1:0] m_tdata,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output      logic [APB_DW-1:0]    prdata,
    output      logic                 pready
);

    cmd_t             cmd;
    sts_t             sts;
    logic [CFG_W-1:0] active_workers_reg;
    logic             cfg_wr;

    // ---------------- configuration register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ACTIVE_WORKERS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_workers_reg <= CFG_W'(1);
        end else if (cfg_wr) begin
            active_workers_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_ACTIVE_WORKERS) ? APB_DW'(active_workers_reg) : '0;

    // ---------------- controller and datapath ----------------
    efws_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    efws_datapath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_tdata        (s_tdata),
        .active_workers (active_workers_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // ---------------- checks ----------------
    // once an item is taken the input is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after a transfer");

    // the sequencer issues at most one datapath operation per cycle
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.load_wr, cmd.scan_run, cmd.div_step, cmd.wb, cmd.out_load}))
        else $error("overlapping datapath commands");

    // a task never ends before it starts
    a_task_order: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && sts.func == FUNC_TASK |=> m_tdata[77:46] >= m_tdata[45:14])
        else $error("task end time below start time");

    // a result is only loaded when the output register is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !m_tvalid || m_tready)
        else $error("output register overwritten");

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for earliest_free_worker_scheduler
// Drives load, task, query and unused-code items over the input stream,
// predicts every result with a software copy of the worker table, and checks
// each transfer on the result stream field by field. Both streams idle and
// stall at random, and the active worker count is rewritten over APB between
// phases.
// ----------------------------------------------------------------------------
module tb
    import efws_pkg::*;
();

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] ADDR_ACTIVE_WORKERS = {REG_ACTIVE_WORKERS, 2'b00};
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam int STALL_LIMIT = 2000;   // cycles without any transfer
    localparam int DRAIN_CYCLES = 64;
    localparam int RAND_PHASES = 9;
    localparam int PHASE_ITEMS = 50;
    localparam int CHAIN_TASKS = 24;

    // fields listed LSB last, so the packed image matches tdata directly
    typedef struct packed {
        logic [AMOUNT_W-1:0] amount;
        logic [CAP_W-1:0]    cap;
        logic [WIDX_W-1:0]   widx;
        logic [FUNC_W-1:0]   fn;
    } sched_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] t_end;
        logic [TIME_W-1:0] t_start;
        logic [CAP_W-1:0]  cap;
        logic [WIDX_W-1:0] worker;
    } sched_out_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] func, [5:2] worker_index, [15:6] capacity, [35:16] task_amount
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [3:0] chosen_worker, [13:4] worker_capacity, [45:14] start_time,
    // [77:46] end_time
    logic [M_TDATA_W-1:0] m_tdata;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predicted worker table and register copy
    logic [CAP_W-1:0]  cap_tbl    [DEF_MAX_WORKERS];
    logic [TIME_W-1:0] finish_tbl [DEF_MAX_WORKERS];
    logic [CFG_W-1:0]  active_reg;

    sched_out_t pending_outputs[$];

    int src_gap_max = 4;
    int sink_gap_max = 4;
    int sink_hold = 0;
    int hold_draw;
    int idle_cycles = 0;
    int err_count = 0;
    int n_load = 0, n_task = 0, n_query = 0, n_unused = 0;
    int n_saturated = 0, n_cfg_writes = 0, n_results = 0;

    earliest_free_worker_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: applies one item to the table copy, returns the result.
    // ------------------------------------------------------------------------
    function automatic sched_out_t schedule_item(input sched_in_t item);
        sched_out_t r;
        int unsigned n;
        int unsigned best;
        logic [TIME_W-1:0] divisor;
        logic [TIME_W-1:0] dur;
        logic [TIME_W:0] sum;
        r = '0;
        // register value 0 behaves as one worker, anything above the table as all
        if (active_reg == 0)
            n = 1;
        else if (active_reg > DEF_MAX_WORKERS)
            n = DEF_MAX_WORKERS;
        else
            n = 32'(active_reg);
        case (item.fn)
            FUNC_LOAD: begin
                cap_tbl[item.widx] = item.cap;
                finish_tbl[item.widx] = '0;
                r.worker = item.widx;
                r.cap = item.cap;
            end
            FUNC_TASK: begin
                best = 0;
                // strict less-than keeps ties on the lowest index
                for (int i = 1; i < n; i++)
                    if (finish_tbl[i] < finish_tbl[best])
                        best = i;
                // zero capacity is kept as is but divides as one
                divisor = (cap_tbl[best] == 0) ? 1 : TIME_W'(cap_tbl[best]);
                dur = (TIME_W'(item.amount) + divisor - 1) / divisor;
                sum = {1'b0, finish_tbl[best]} + {1'b0, dur};
                r.worker = best[WIDX_W-1:0];
                r.cap = cap_tbl[best];
                r.t_start = finish_tbl[best];
                r.t_end = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                if (sum[TIME_W])
                    n_saturated++;
                finish_tbl[best] = r.t_end;
            end
            FUNC_QUERY: begin
                for (int i = 0; i < n; i++)
                    if (finish_tbl[i] > r.t_end)
                        r.t_end = finish_tbl[i];
            end
            default: ;   // unused code: all-zero result, table untouched
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------------
    // tvalid is only dropped when a gap is drawn, so back-to-back transfers
    // never see a low and a high assignment in the same step
    task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [WIDX_W-1:0] widx,
                             input logic [CAP_W-1:0] cap, input logic [AMOUNT_W-1:0] amount);
        sched_in_t item;
        sched_out_t want;
        int gap;
        item.fn = fn;
        item.widx = widx;
        item.cap = cap;
        item.amount = amount;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(item);
        do @(posedge aclk); while (!s_tready);
        want = schedule_item(item);
        pending_outputs = {pending_outputs, want};
        case (fn)
            FUNC_LOAD:  n_load++;
            FUNC_TASK:  n_task++;
            FUNC_QUERY: n_query++;
            default:    n_unused++;
        endcase
    endtask

    // hold the source until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_outputs.size() != 0) @(posedge aclk);
    endtask

    // setup then access phase; upper pwdata bits carry noise, only the low
    // five bits are the register
    task automatic write_active_workers(input logic [CFG_W-1:0] val);
        logic [APB_DW-1:0] word;
        word = $urandom();
        word[CFG_W-1:0] = val;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_ACTIVE_WORKERS;
        pwdata <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        active_reg = val;
        n_cfg_writes++;
    endtask

    function automatic logic [CAP_W-1:0] rand_cap();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel < 5)
            return CAP_W'($urandom_range(1, 16));
        else
            return CAP_W'($urandom());
    endfunction

    function automatic logic [AMOUNT_W-1:0] rand_amount();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel < 5)
            return AMOUNT_W'($urandom_range(1, 64));
        else
            return AMOUNT_W'($urandom());
    endfunction

    // ------------------------------------------------------------------------
    // Sink side and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got_v,
                                   input logic [TIME_W-1:0] want_v);
        err_count++;
        $display("mismatch %s at %0t ns: got 0x%0h want 0x%0h", what, $realtime,
                 got_v, want_v);
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] data);
        sched_out_t got;
        sched_out_t want;
        got = sched_out_t'(data[$bits(sched_out_t)-1:0]);
        n_results++;
        if (pending_outputs.size() == 0) begin
            report_mismatch("result with nothing pending, end_time", got.t_end, '0);
        end else begin
            want = pending_outputs.pop_front();
            if (got.worker !== want.worker)
                report_mismatch("chosen_worker", got.worker, want.worker);
            if (got.cap !== want.cap)
                report_mismatch("worker_capacity", got.cap, want.cap);
            if (got.t_start !== want.t_start)
                report_mismatch("start_time", got.t_start, want.t_start);
            if (got.t_end !== want.t_end)
                report_mismatch("end_time", got.t_end, want.t_end);
        end
    endtask

    // tready drops for a random number of cycles after a transfer when a nonzero hold is drawn
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                check_result(m_tdata);
                hold_draw = $urandom_range(0, sink_gap_max);
                if (hold_draw > 0) begin
                    m_tready <= 1'b0;
                    sink_hold <= hold_draw;
                end
            end else if (!m_tready) begin
                if (sink_hold <= 1)
                    m_tready <= 1'b1;
                sink_hold <= sink_hold - 1;
            end
        end
    end

    // watchdog: any transfer on either stream restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_outputs.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset table: one worker active, capacity one, finish zero
    task automatic test_after_reset();
        send_item(FUNC_QUERY, 4'($urandom()), 10'($urandom()), 20'($urandom()));
        send_item(FUNC_TASK, 4'($urandom()), 10'($urandom()), '0);   // zero task
        send_item(FUNC_TASK, 4'($urandom()), 10'($urandom()), 20'd7);
        send_item(FUNC_UNUSED, '1, '1, '1);
        send_item(FUNC_QUERY, '0, '0, '0);
    endtask

    // active count extremes, capacity extremes, zero capacity, ties
    task automatic test_worker_table();
        drain_results();
        write_active_workers(5'd0);   // behaves as one worker
        send_item(FUNC_LOAD, 4'd15, '0, 20'($urandom()));
        send_item(FUNC_TASK, '0, '0, 20'd3);
        drain_results();
        write_active_workers(5'd31);  // clamps to the full table
        send_item(FUNC_LOAD, 4'd0, 10'd1023, '0);
        send_item(FUNC_LOAD, 4'd5, 10'd1, '1);
        send_item(FUNC_TASK, '0, '0, '1);        // all tied, lowest index wins
        // walk the remaining idle workers so worker 15 (zero capacity) is reached
        for (int i = 0; i < 15; i++)
            send_item(FUNC_TASK, 4'($urandom()), 10'($urandom()),
                      AMOUNT_W'($urandom_range(1, 2000)));
        send_item(FUNC_QUERY, 4'($urandom()), 10'($urandom()), 20'($urandom()));
    endtask

    // one worker, divisor one, full tasks back to back with no idling; the
    // finish time climbs by the largest step on every transfer
    task automatic test_full_task_chain();
        int keep_src, keep_sink;
        keep_src = src_gap_max;
        keep_sink = sink_gap_max;
        drain_results();
        write_active_workers(5'd1);
        src_gap_max = 0;
        sink_gap_max = 0;
        send_item(FUNC_LOAD, 4'd0, CAP_W'($urandom_range(0, 1)), '0);
        for (int i = 0; i < CHAIN_TASKS; i++)
            send_item(FUNC_TASK, '0, '0, '1);
        send_item(FUNC_QUERY, '0, '0, '0);
        send_item(FUNC_LOAD, 4'd0, 10'd1, '0);
        src_gap_max = keep_src;
        sink_gap_max = keep_sink;
    endtask

    // phases with fresh settings: loads of the active workers, then a mix
    task automatic test_random_mix();
        logic [CFG_W-1:0] setting;
        int unsigned n;
        int sel;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: setting = 5'd1;
                1: setting = 5'd16;
                2: setting = 5'd0;
                3: setting = 5'd31;
                default: setting = CFG_W'($urandom_range(1, 16));
            endcase
            drain_results();
            write_active_workers(setting);
            // every third phase runs both streams without idling
            src_gap_max = (ph % 3 == 2) ? 0 : 4;
            sink_gap_max = (ph % 3 == 2) ? 0 : 4;
            n = (setting == 0) ? 1 : (setting > DEF_MAX_WORKERS ? DEF_MAX_WORKERS : setting);
            for (int w = 0; w < n && w < PHASE_ITEMS / 2; w++)
                send_item(FUNC_LOAD, WIDX_W'(w), rand_cap(), 20'($urandom()));
            for (int k = (n < PHASE_ITEMS / 2 ? n : PHASE_ITEMS / 2); k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 15)
                    send_item(FUNC_LOAD, 4'($urandom()), rand_cap(), 20'($urandom()));
                else if (sel < 78)
                    send_item(FUNC_TASK, 4'($urandom()), 10'($urandom()), rand_amount());
                else if (sel < 93)
                    send_item(FUNC_QUERY, 4'($urandom()), 10'($urandom()), 20'($urandom()));
                else
                    send_item(FUNC_UNUSED, 4'($urandom()), 10'($urandom()), 20'($urandom()));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < DEF_MAX_WORKERS; i++) begin
            cap_tbl[i] = CAP_W'(1);
            finish_tbl[i] = '0;
        end
        active_reg = CFG_W'(1);
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_worker_table();
        test_full_task_chain();
        test_random_mix();

        // let the last item run out, then allow for the block's latency
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d loads, %0d tasks, %0d queries, %0d unused codes; %0d results",
                 n_load, n_task, n_query, n_unused, n_results);
        $display("%0d register writes, %0d saturated finish times, %0d mismatches",
                 n_cfg_writes, n_saturated, err_count);
        if (err_count == 0 && pending_outputs.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
